// File: rtl/bol_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded ordered list.
// No dependencies; used by every module in rtl/.
package bol_pkg;

   // List capacity and derived widths
   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 5;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int VAL_W = 32;
   localparam int OUT_CNT_W = 5;

   typedef enum logic [1:0] {
      OP_QUERY      = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_PUSH_BACK  = 2'd2,
      OP_DELETE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_POS = 2'd2
   } status_type;

   // What a cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_FROM_LEFT  = 2'd1,
      CELL_FROM_RIGHT = 2'd2,
      CELL_LOAD       = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          last_sel;   // cell holds the back element after this op
   } cell_cmd_type;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] count;   // element count after this op
   } ctrl_result_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [VAL_W-1:0]   value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [OUT_CNT_W-1:0]      count;
      logic signed [VAL_W-1:0]   first_value;
      logic signed [VAL_W-1:0]   last_value;
      logic                      is_empty;
   } rsp_type;

endpackage

// File: rtl/bol_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one value, takes from a neighbor.
// Depends on bol_pkg.
module bol_cell (
   input  logic                            clock,
   input  bol_pkg::cell_cmd_type           cmd,
   input  logic signed [bol_pkg::VAL_W-1:0] left_value,
   input  logic signed [bol_pkg::VAL_W-1:0] right_value,
   input  logic signed [bol_pkg::VAL_W-1:0] load_value,
   output logic signed [bol_pkg::VAL_W-1:0] value,
   output logic signed [bol_pkg::VAL_W-1:0] next_value,
   output logic signed [bol_pkg::VAL_W-1:0] last_value
);

   logic signed [bol_pkg::VAL_W-1:0] value_ff;
   logic signed [bol_pkg::VAL_W-1:0] value_in;

   // Next value by command
   always_comb begin
      unique case (cmd.mode)
         bol_pkg::CELL_FROM_LEFT:  value_in = left_value;
         bol_pkg::CELL_FROM_RIGHT: value_in = right_value;
         bol_pkg::CELL_LOAD:       value_in = load_value;
         default:                  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign next_value = value_in;
   // Masked contribution to the back-value OR tree
   assign last_value = cmd.last_sel ? value_in : '0;

endmodule

// File: rtl/bol_ctrl.sv
`timescale 1ns / 1ps
// Operation decode and element count for the list: per-cell commands and status.
// Depends on bol_pkg.
module bol_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  bol_pkg::req_type          req,
   output bol_pkg::cell_cmd_type     cmd [bol_pkg::DEPTH],
   output bol_pkg::ctrl_result_type  result
);

   logic [bol_pkg::CNT_W-1:0] count_ff;
   logic [bol_pkg::CNT_W-1:0] count_in;
   logic                      full;
   logic                      pos_bad;
   logic                      do_front;
   logic                      do_back;
   logic                      do_del;
   bol_pkg::status_type       status;

   assign full    = (count_ff == bol_pkg::CNT_W'(bol_pkg::DEPTH));
   assign pos_bad = (req.position == '0) ||
                    (bol_pkg::CMP_W'(req.position) > bol_pkg::CMP_W'(count_ff));

   // Operation decode
   always_comb begin
      do_front = 1'b0;
      do_back  = 1'b0;
      do_del   = 1'b0;
      status   = bol_pkg::ST_OK;
      count_in = count_ff;
      unique case (req.operation)
         bol_pkg::OP_PUSH_FRONT, bol_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status = bol_pkg::ST_FULL;
            end else begin
               do_front = (req.operation == bol_pkg::OP_PUSH_FRONT);
               do_back  = (req.operation == bol_pkg::OP_PUSH_BACK);
               count_in = count_ff + 1'b1;
            end
         end
         bol_pkg::OP_DELETE: begin
            if (pos_bad) begin
               status = bol_pkg::ST_BAD_POS;
            end else begin
               do_del   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Per-cell commands: front push shifts right, back push loads the free cell, delete closes the gap
   always_comb begin
      for (int i = 0; i < bol_pkg::DEPTH; i++) begin
         cmd[i].mode     = bol_pkg::CELL_HOLD;
         cmd[i].last_sel = (bol_pkg::CNT_W'(i) + 1'b1 == count_in);
         if (accept) begin
            if (do_front) begin
               cmd[i].mode = bol_pkg::CELL_FROM_LEFT;
            end else if (do_back && (bol_pkg::CNT_W'(i) == count_ff)) begin
               cmd[i].mode = bol_pkg::CELL_LOAD;
            end else if (do_del &&
                         (bol_pkg::CMP_W'(i) + 1'b1 >= bol_pkg::CMP_W'(req.position))) begin
               cmd[i].mode = bol_pkg::CELL_FROM_RIGHT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign result.status = status;
   assign result.count  = count_in;

`ifndef SYNTHESIS
   // Count never leaves its range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bol_pkg::CNT_W'(bol_pkg::DEPTH))
      else $error("element count above capacity");

   // A successful push grows the list by exactly one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (do_front || do_back) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the count by one");
`endif

endmodule

// File: rtl/bounded_ordered_list.sv
`timescale 1ns / 1ps
// Top level of the bounded ordered list: cell chain, control and result register.
// Depends on bol_pkg, bol_cell and bol_ctrl.

// Ordered list of up to DEPTH (16) signed 32-bit values in a chain of cells,
// cell 0 holding the front. Each request transfer does one operation (query,
// push front, push back, delete at a 1-based position) and yields exactly one
// result transfer with status, count, front and back values and an empty flag.
// A front push shifts the whole chain one cell right and a delete shifts the
// cells from the position onward one cell left, both at the same edge. The
// result is registered and appears in the cycle after its request; with the
// result channel ready, one request is taken per cycle. The result register
// lets a new request in while the previous result is taken.
module bounded_ordered_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bol_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bol_pkg::rsp_type rsp_data
);

   bol_pkg::cell_cmd_type            cmd [bol_pkg::DEPTH];
   bol_pkg::ctrl_result_type         result;
   logic signed [bol_pkg::VAL_W-1:0] cell_value [bol_pkg::DEPTH];
   logic signed [bol_pkg::VAL_W-1:0] cell_next  [bol_pkg::DEPTH];
   logic signed [bol_pkg::VAL_W-1:0] cell_last  [bol_pkg::DEPTH];
   logic signed [bol_pkg::VAL_W-1:0] last_value;
   logic                             accept;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   bol_pkg::rsp_type                 rsp_ff;
   bol_pkg::rsp_type                 rsp_in;

   // Request handshake: take one when the result slot is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   bol_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cmd    (cmd),
      .result (result)
   );

   // Cell chain
   for (genvar i = 0; i < bol_pkg::DEPTH; i++) begin : g_cell
      logic signed [bol_pkg::VAL_W-1:0] left_value;
      logic signed [bol_pkg::VAL_W-1:0] right_value;
      if (i == 0) begin : g_head
         assign left_value = req_data.value;
      end else begin : g_body
         assign left_value = cell_value[i-1];
      end
      if (i == bol_pkg::DEPTH - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end
      bol_cell u_cell (
         .clock       (clock),
         .cmd         (cmd[i]),
         .left_value  (left_value),
         .right_value (right_value),
         .load_value  (req_data.value),
         .value       (cell_value[i]),
         .next_value  (cell_next[i]),
         .last_value  (cell_last[i])
      );
   end

   // Back value: exactly one cell is selected, none when empty
   always_comb begin
      last_value = '0;
      for (int i = 0; i < bol_pkg::DEPTH; i++) begin
         last_value = last_value | cell_last[i];
      end
   end

   // Result assembly
   always_comb begin
      rsp_in.status      = result.status;
      rsp_in.count       = bol_pkg::OUT_CNT_W'(bol_pkg::CMP_W'(result.count));
      rsp_in.is_empty    = (result.count == '0);
      rsp_in.first_value = rsp_in.is_empty ? '0 : cell_next[0];
      rsp_in.last_value  = last_value;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Every request transfer leaves a result behind
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("request transfer without a result");

   // An empty list reports zero front and back values
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_empty |-> rsp_ff.first_value == '0 &&
         rsp_ff.last_value == '0)
      else $error("empty result with nonzero values");

   // A successful back push shows the pushed value at the back
   a_back_push: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.operation == bol_pkg::OP_PUSH_BACK |=>
         rsp_ff.status != bol_pkg::ST_OK ||
         rsp_ff.last_value == $past(req_data.value))
      else $error("back push value not at the back");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_ordered_list: mixed list operations with random stalls.
// Depends on rtl/bol_pkg.sv and rtl/bounded_ordered_list.sv.
module testbench;
   import bol_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int IDLE_PCT       = 19;
   localparam int ITEM_TOTAL     = 1250;
   localparam int QUIET_START    = 700;
   localparam int QUIET_END      = 1100;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 8;
   localparam int REPORT_LIMIT   = 10;

   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_ALL_ONES = '1;

   // One queued request, optionally held back until all results are in
   typedef struct {
      req_type item;
      bit      settle_first;
   } stim_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_entry_type           stim_items[$];
   rsp_type                  pending_results[$];
   logic signed [VAL_W-1:0]  held_values[$];   // predicted list contents, front first
   int                       gen_count;         // list size as seen by the generator
   int                       reset_cycles = 0;
   int                       cycle_no = 0;
   int                       idle_cycles = 0;
   int                       error_count = 0;
   bit                       req_taken = 1'b0;
   rsp_type                  want_rsp;

   bounded_ordered_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one operation to the predicted list and build the result it gives
   function automatic rsp_type list_apply(input req_type r);
      rsp_type res;
      res = '0;
      res.status = ST_OK;
      case (r.operation)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held_values.size() >= DEPTH)
               res.status = ST_FULL;
            else if (r.operation == OP_PUSH_FRONT)
               held_values.push_front(r.value);
            else
               held_values.push_back(r.value);
         end
         OP_DELETE: begin
            if (r.position == 0 || int'(r.position) > held_values.size())
               res.status = ST_BAD_POS;
            else
               held_values.delete(int'(r.position) - 1);
         end
         default: ;
      endcase
      res.count    = OUT_CNT_W'(held_values.size());
      res.is_empty = (held_values.size() == 0);
      if (held_values.size() != 0) begin
         res.first_value = held_values[0];
         res.last_value  = held_values[$];
      end
      return res;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      if (got.status !== want.status)
         note_error($sformatf("status: expected %0d, got %0d", want.status, got.status));
      if (got.count !== want.count)
         note_error($sformatf("count: expected %0d, got %0d", want.count, got.count));
      if (got.first_value !== want.first_value)
         note_error($sformatf("first_value: expected %0d, got %0d",
                              want.first_value, got.first_value));
      if (got.last_value !== want.last_value)
         note_error($sformatf("last_value: expected %0d, got %0d",
                              want.last_value, got.last_value));
      if (got.is_empty !== want.is_empty)
         note_error($sformatf("is_empty: expected %0b, got %0b",
                              want.is_empty, got.is_empty));
   endtask

   // Queue one request and track the list size it leaves behind
   task automatic add_item(input op_type op, input logic signed [VAL_W-1:0] val,
                           input int pos, input bit settle);
      stim_entry_type e;
      e.item.operation = op;
      e.item.value     = val;
      e.item.position  = POS_W'(pos);
      e.settle_first   = settle;
      stim_items.push_back(e);
      if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_count < DEPTH)
         gen_count++;
      else if (op == OP_DELETE && pos >= 1 && pos <= gen_count)
         gen_count--;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      case (roll)
         0, 1:    return VAL_MIN;
         2, 3:    return VAL_MAX;
         4, 5:    return VAL_ALL_ONES;
         6:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Stimulus, then wait for the pipeline to empty
   initial begin
      int   mode;
      int   run_len;
      int   roll;
      int   pos;
      bit   settle;
      op_type op;

      gen_count = 0;

      // Empty list: query and bad deletes
      add_item(OP_QUERY, VAL_ALL_ONES, 31, 1'b0);
      add_item(OP_DELETE, '0, 0, 1'b0);
      add_item(OP_DELETE, '0, 1, 1'b0);
      // Fill to capacity with extreme values at both ends
      for (int i = 0; i < DEPTH; i++) begin
         case (i % 4)
            0:       add_item(OP_PUSH_FRONT, VAL_MIN, 16, 1'b0);
            1:       add_item(OP_PUSH_BACK, VAL_MAX, 0, 1'b0);
            2:       add_item(OP_PUSH_FRONT, VAL_ALL_ONES, 1, 1'b0);
            default: add_item(OP_PUSH_BACK, $urandom, 8, 1'b0);
         endcase
      end
      // Pushes into a full list, then deletes at the back, past the end, front, middle, position 0
      add_item(OP_PUSH_FRONT, 32'sd5, 0, 1'b0);
      add_item(OP_PUSH_BACK, 32'sd6, 0, 1'b0);
      add_item(OP_QUERY, '0, 0, 1'b0);
      add_item(OP_DELETE, '0, DEPTH, 1'b0);
      add_item(OP_DELETE, '0, DEPTH, 1'b0);
      add_item(OP_DELETE, '0, 1, 1'b0);
      add_item(OP_DELETE, '0, 7, 1'b0);
      add_item(OP_DELETE, '0, 0, 1'b0);

      // Random runs that lean toward filling, draining, or neither
      while (stim_items.size() < ITEM_TOTAL) begin
         mode    = $urandom_range(0, 2);
         run_len = $urandom_range(8, 40);
         for (int k = 0; k < run_len; k++) begin
            settle = (stim_items.size() == 400 || stim_items.size() == 900);
            roll = $urandom_range(0, 99);
            case (mode)
               0:       op = (roll < 40) ? OP_PUSH_FRONT : (roll < 75) ? OP_PUSH_BACK :
                             (roll < 80) ? OP_QUERY : OP_DELETE;
               1:       op = (roll < 10) ? OP_PUSH_FRONT : (roll < 20) ? OP_PUSH_BACK :
                             (roll < 25) ? OP_QUERY : OP_DELETE;
               default: op = (roll < 30) ? OP_PUSH_FRONT : (roll < 60) ? OP_PUSH_BACK :
                             (roll < 70) ? OP_QUERY : OP_DELETE;
            endcase
            pos = $urandom_range(0, DEPTH);
            if (op == OP_DELETE) begin
               roll = $urandom_range(0, 99);
               if (gen_count > 0 && roll < 85)
                  pos = $urandom_range(1, gen_count);
               else if (roll < 92)
                  pos = 0;
               else if (gen_count < DEPTH)
                  pos = gen_count + 1;
            end
            add_item(op, pick_value(), pos, settle);
         end
      end

      while (stim_items.size() != 0 || req_valid)
         @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Driver: reset, request channel and result back-pressure, all at the falling edge
   always @(negedge clock) begin
      if (reset_cycles < RESET_CYCLES) begin
         reset_cycles <= reset_cycles + 1;
      end else begin
         reset <= 1'b0;
         rsp_ready <= (cycle_no >= QUIET_START && cycle_no < QUIET_END) ||
                      ($urandom_range(0, 99) >= IDLE_PCT);
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (stim_items.size() != 0 &&
                (!stim_items[0].settle_first || pending_results.size() == 0) &&
                ((cycle_no >= QUIET_START && cycle_no < QUIET_END) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= stim_items[0].item;
               void'(stim_items.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      if (!reset) begin
         cycle_no++;
         idle_cycles++;
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            idle_cycles = 0;
            pending_results.push_back(list_apply(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (pending_results.size() == 0) begin
               note_error("result transfer with no request outstanding");
            end else begin
               want_rsp = pending_results.pop_front();
               check_result(rsp_data, want_rsp);
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
rtl/bol_pkg.sv
rtl/bol_cell.sv
rtl/bol_ctrl.sv
rtl/bounded_ordered_list.sv
dv/testbench.sv
